// ===== rtl/cache_partition_gear_policy_defines.svh =====
`ifndef CACHE_PARTITION_GEAR_POLICY_DEFINES_SVH
`define CACHE_PARTITION_GEAR_POLICY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPGP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpgp_pkg.sv =====
package cpgp_pkg;

    typedef struct packed {
        logic [23:0] cpu_freq_c0;
        logic [23:0] cpu_freq_c1;
        logic [11:0] gpu_freq_mhz;
    } t_in_word;

    typedef struct packed {
        logic [1:0] cpu_gear;
        logic [1:0] gpu_gear;
        logic       from_gpu_policy;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [23:0] boost_thresh_c0;
        logic [23:0] boost_thresh_c1;
        logic [23:0] restore_thresh_c0;
        logic [23:0] restore_thresh_c1;
        logic [47:0] band_c0;
        logic [47:0] band_c1;
        logic [11:0] gpu_low_thresh;
        logic [11:0] gpu_high_thresh;
    } t_cfg;

    typedef struct packed {
        logic [1:0] count;
        t_out_word  res0;
        t_out_word  res1;
    } t_res_pair;

    typedef enum logic [2:0] {
        CPU_NONE    = 3'd0,
        CPU_BOOST   = 3'd1,
        CPU_RISE    = 3'd2,
        CPU_RESTORE = 3'd3,
        CPU_FALL    = 3'd4
    } t_cpu_state;

    typedef enum logic [1:0] {
        GPU_NONE  = 2'd0,
        GPU_BELOW = 2'd1,
        GPU_IN    = 2'd2,
        GPU_ABOVE = 2'd3
    } t_gpu_state;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_C0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_C1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_C0 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_C1 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_C0    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_C1    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_LOW    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_HIGH   = 4'd7;

    localparam logic [1:0] GEAR_0 = 2'd0;
    localparam logic [1:0] GEAR_1 = 2'd1;
    localparam logic [1:0] GEAR_3 = 2'd3;

endpackage

// ===== rtl/cpgp_policy.sv =====
module cpgp_policy (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cpgp_pkg::t_in_word i_word,
    input  cpgp_pkg::t_cfg    i_cfg,
    output cpgp_pkg::t_res_pair o_res
);
    import cpgp_pkg::*;

    logic [23:0] r_last_c0;
    logic [23:0] r_last_c1;
    t_cpu_state  r_cpu_state;
    t_cpu_state  n_cpu_state;
    t_gpu_state  r_gpu_state;
    t_gpu_state  n_gpu_state;

    logic [23:0] w_c0;
    logic [23:0] w_c1;
    logic [23:0] w_lo0;
    logic [23:0] w_hi0;
    logic [23:0] w_lo1;
    logic [23:0] w_hi1;
    logic        w_rose0;
    logic        w_rose1;
    logic        w_cpu_emit;
    logic        w_gpu_emit;
    t_out_word   w_cpu_res;
    t_out_word   w_gpu_res;

    assign w_c0  = i_word.cpu_freq_c0;
    assign w_c1  = i_word.cpu_freq_c1;
    assign w_lo0 = i_cfg.band_c0[23:0];
    assign w_hi0 = i_cfg.band_c0[47:24];
    assign w_lo1 = i_cfg.band_c1[23:0];
    assign w_hi1 = i_cfg.band_c1[47:24];

    assign w_rose0 = (w_c0 > r_last_c0) && ((w_c0 - r_last_c0) > i_cfg.boost_thresh_c0);
    assign w_rose1 = (w_c1 > r_last_c1) && ((w_c1 - r_last_c1) > i_cfg.boost_thresh_c1);

    always_comb begin
        n_cpu_state = r_cpu_state;
        w_cpu_emit  = 1'b0;
        w_cpu_res   = '{cpu_gear: GEAR_0, gpu_gear: GEAR_3, from_gpu_policy: 1'b0,
                        last: 1'b0};
        if (i_word.gpu_freq_mhz < i_cfg.gpu_low_thresh) begin
            if (r_cpu_state != CPU_BOOST && (w_rose0 || w_rose1)) begin
                n_cpu_state = CPU_BOOST;
            end else if (r_cpu_state != CPU_RISE &&
                         (w_c0 >= r_last_c0 || w_c1 >= r_last_c1)) begin
                n_cpu_state = CPU_RISE;
                w_cpu_emit  = 1'b1;
            end else if (r_cpu_state != CPU_RESTORE &&
                         w_c0 <= i_cfg.restore_thresh_c0 &&
                         w_c1 <= i_cfg.restore_thresh_c1) begin
                n_cpu_state = CPU_RESTORE;
                w_cpu_emit  = 1'b1;
                w_cpu_res.cpu_gear = GEAR_1;
                w_cpu_res.gpu_gear = GEAR_1;
            end else if (r_cpu_state != CPU_FALL &&
                         w_c0 < r_last_c0 && w_c1 < r_last_c1) begin
                n_cpu_state = CPU_FALL;
            end
        end
    end

    always_comb begin
        n_gpu_state = r_gpu_state;
        w_gpu_emit  = 1'b0;
        w_gpu_res   = '{cpu_gear: GEAR_3, gpu_gear: GEAR_0, from_gpu_policy: 1'b1,
                        last: 1'b1};
        if (i_word.gpu_freq_mhz > i_cfg.gpu_high_thresh) begin
            if (r_gpu_state != GPU_BELOW && (w_c0 < w_lo0 || w_c1 < w_lo1)) begin
                n_gpu_state = GPU_BELOW;
                w_gpu_emit  = 1'b1;
            end else if (r_gpu_state != GPU_IN &&
                         ((w_c0 >= w_lo0 && w_c0 < w_hi0) ||
                          (w_c1 >= w_lo1 && w_c1 < w_hi1))) begin
                n_gpu_state = GPU_IN;
                w_gpu_emit  = 1'b1;
                w_gpu_res.cpu_gear = GEAR_1;
                w_gpu_res.gpu_gear = GEAR_1;
            end else if (r_gpu_state != GPU_ABOVE &&
                         (w_c0 >= w_hi0 || w_c1 >= w_hi1)) begin
                n_gpu_state = GPU_ABOVE;
                w_gpu_emit  = 1'b1;
                w_gpu_res.cpu_gear = GEAR_0;
                w_gpu_res.gpu_gear = GEAR_1;
            end
        end
    end

    always_comb begin
        o_res = '{count: 2'd0, res0: w_gpu_res, res1: w_gpu_res};
        if (i_fire) begin
            if (w_cpu_emit && w_gpu_emit) begin
                o_res.count = 2'd2;
                o_res.res0  = w_cpu_res;
            end else if (w_cpu_emit) begin
                o_res.count     = 2'd1;
                o_res.res0      = w_cpu_res;
                o_res.res0.last = 1'b1;
            end else if (w_gpu_emit) begin
                o_res.count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_c0   <= '0;
            r_last_c1   <= '0;
            r_cpu_state <= CPU_NONE;
            r_gpu_state <= GPU_NONE;
        end else if (i_fire) begin
            r_last_c0   <= w_c0;
            r_last_c1   <= w_c1;
            r_cpu_state <= n_cpu_state;
            r_gpu_state <= n_gpu_state;
        end
    end

endmodule

// ===== rtl/cpgp_res_queue.sv =====
`include "cache_partition_gear_policy_defines.svh"

module cpgp_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpgp_pkg::t_res_pair i_push,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cpgp_pkg::t_out_word o_out_word
);
    import cpgp_pkg::*;

    localparam int QDEPTH = 4;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_out_word        r_q [QDEPTH];
    t_out_word        n_q [QDEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_base;
    logic             w_pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_q[0];
    assign o_room      = (r_cnt <= CNT_W'(QDEPTH - 2));
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_base      = r_cnt - CNT_W'(w_pop);

    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (w_pop && i < QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.count != 2'd0 && w_base == CNT_W'(i)) begin
                n_q[i] = i_push.res0;
            end
            if (i_push.count == 2'd2 && w_base + CNT_W'(1) == CNT_W'(i)) begin
                n_q[i] = i_push.res1;
            end
        end
        n_cnt = w_base + CNT_W'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `CPGP_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(QDEPTH), "result queue overfilled")
    `CPGP_ASSERT_NOW(a_push_room, i_push.count != 2'd0, o_room, "results pushed without room")
    `CPGP_ASSERT_NOW(a_pair_last, i_push.count == 2'd2, i_push.res1.last && !i_push.res0.last, "bad last marks on a pair")
    `CPGP_ASSERT_NEXT(a_pop_only, w_pop && i_push.count == 2'd0, r_cnt == $past(r_cnt) - CNT_W'(1), "pop miscounted")

endmodule

// ===== rtl/cache_partition_gear_policy.sv =====
// An accepted input word is registered and decided once the result queue has room;
// its result words are registered in the result queue and offered from there.
// Throughput: one input word per cycle while the result queue has room and each word
// yields at most one result; when both policies emit, the one-word output limits it.
// Reset: synchronous, active low; clears history, policy states and the result
// queue, and loads the default thresholds and bands.
module cache_partition_gear_policy (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  cpgp_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output cpgp_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_we,
    input  logic [cpgp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cpgp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cpgp_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    t_cfg      r_cfg;
    logic      w_room;
    logic      w_fire;
    t_res_pair w_res;

    assign w_fire     = r_in_valid && w_room;
    assign o_in_stall = r_in_valid && !w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_thresh_c0   <= 24'd1500000;
            r_cfg.boost_thresh_c1   <= 24'd1500000;
            r_cfg.restore_thresh_c0 <= 24'd1000000;
            r_cfg.restore_thresh_c1 <= 24'd1400000;
            r_cfg.band_c0           <= {24'd1996800, 24'd115200};
            r_cfg.band_c1           <= {24'd3072000, 24'd1689600};
            r_cfg.gpu_low_thresh    <= 12'd443;
            r_cfg.gpu_high_thresh   <= 12'd607;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BOOST_C0:   r_cfg.boost_thresh_c0   <= i_cfg_data[23:0];
                CFG_BOOST_C1:   r_cfg.boost_thresh_c1   <= i_cfg_data[23:0];
                CFG_RESTORE_C0: r_cfg.restore_thresh_c0 <= i_cfg_data[23:0];
                CFG_RESTORE_C1: r_cfg.restore_thresh_c1 <= i_cfg_data[23:0];
                CFG_BAND_C0:    r_cfg.band_c0           <= i_cfg_data[47:0];
                CFG_BAND_C1:    r_cfg.band_c1           <= i_cfg_data[47:0];
                CFG_GPU_LOW:    r_cfg.gpu_low_thresh    <= i_cfg_data[11:0];
                CFG_GPU_HIGH:   r_cfg.gpu_high_thresh   <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    cpgp_policy u_policy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_word  (r_in_word),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    cpgp_res_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sim/tb_cache_partition_gear_policy.sv =====
`timescale 1ns / 100ps

module tb_cache_partition_gear_policy;
    import cpgp_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 145;
    localparam int HOLD_OFF_CYCLES = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    localparam logic [23:0] DEF_BOOST = 24'd1500000;
    localparam logic [23:0] DEF_RESTORE_C0 = 24'd1000000;
    localparam logic [23:0] DEF_RESTORE_C1 = 24'd1400000;
    localparam logic [47:0] DEF_BAND_C0 = {24'd1996800, 24'd115200};
    localparam logic [47:0] DEF_BAND_C1 = {24'd3072000, 24'd1689600};
    localparam logic [11:0] DEF_GPU_LOW = 12'd443;
    localparam logic [11:0] DEF_GPU_HIGH = 12'd607;

    typedef enum logic [1:0] {
        ROW_ITEM   = 2'd0,
        ROW_PINNED = 2'd1,
        ROW_CFG    = 2'd2
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_in_word               word;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   has_gear;
        t_out_word              gear;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_word               i_in_word = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_word              o_out_word;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    cache_partition_gear_policy uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    t_cfg        pol_cfg;
    logic [23:0] hist_c0;
    logic [23:0] hist_c1;
    t_cpu_state  cpu_st;
    t_gpu_state  gpu_st;

    t_out_word   gear_expect_q[$];
    t_row        dir_rows[$];

    // A pinned directed row replaces the predicted words with the gear written out in it, or with none.
    bit          pin_valid = 1'b0;
    bit          pin_has_gear;
    t_out_word   pin_gear;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          rx_hold_len = 0;

    int          err_count = 0;
    int          ticks_taken = 0;
    int          gears_checked = 0;
    int          dual_ticks = 0;
    int          settings_run = 1;

    t_out_word   pred_a;
    t_out_word   pred_b;
    t_out_word   want_w;
    int          pred_n;

    function automatic t_out_word gear_word(input logic [1:0] cg, input logic [1:0] gg,
                                            input logic src);
        t_out_word w;
        w.cpu_gear = cg;
        w.gpu_gear = gg;
        w.from_gpu_policy = src;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic void model_reset();
        pol_cfg.boost_thresh_c0 = DEF_BOOST;
        pol_cfg.boost_thresh_c1 = DEF_BOOST;
        pol_cfg.restore_thresh_c0 = DEF_RESTORE_C0;
        pol_cfg.restore_thresh_c1 = DEF_RESTORE_C1;
        pol_cfg.band_c0 = DEF_BAND_C0;
        pol_cfg.band_c1 = DEF_BAND_C1;
        pol_cfg.gpu_low_thresh = DEF_GPU_LOW;
        pol_cfg.gpu_high_thresh = DEF_GPU_HIGH;
        hist_c0 = '0;
        hist_c1 = '0;
        cpu_st = CPU_NONE;
        gpu_st = GPU_NONE;
    endfunction

    function automatic void cfg_apply(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_BOOST_C0:   pol_cfg.boost_thresh_c0 = d[23:0];
            CFG_BOOST_C1:   pol_cfg.boost_thresh_c1 = d[23:0];
            CFG_RESTORE_C0: pol_cfg.restore_thresh_c0 = d[23:0];
            CFG_RESTORE_C1: pol_cfg.restore_thresh_c1 = d[23:0];
            CFG_BAND_C0:    pol_cfg.band_c0 = d;
            CFG_BAND_C1:    pol_cfg.band_c1 = d;
            CFG_GPU_LOW:    pol_cfg.gpu_low_thresh = d[11:0];
            CFG_GPU_HIGH:   pol_cfg.gpu_high_thresh = d[11:0];
            default: ;
        endcase
    endfunction

    function automatic bit rose_past(input logic [23:0] cur, input logic [23:0] prev,
                                     input logic [23:0] th);
        return (cur > prev) && ((cur - prev) > th);
    endfunction

    // Advances both policy machines by one tick; returns the number of gear words.
    function automatic int gear_policy_step(input t_in_word w, output t_out_word r0,
                                            output t_out_word r1);
        logic [23:0] c0, c1, p0, p1, lo0, hi0, lo1, hi1;
        logic [11:0] g;
        t_out_word   gpu_w;
        bit          gpu_hit;
        int          n;
        c0 = w.cpu_freq_c0;
        c1 = w.cpu_freq_c1;
        g = w.gpu_freq_mhz;
        p0 = hist_c0;
        p1 = hist_c1;
        hist_c0 = c0;
        hist_c1 = c1;
        r0 = '0;
        r1 = '0;
        n = 0;
        gpu_hit = 1'b0;
        gpu_w = '0;

        if (g < pol_cfg.gpu_low_thresh) begin
            if (cpu_st != CPU_BOOST && (rose_past(c0, p0, pol_cfg.boost_thresh_c0) ||
                                        rose_past(c1, p1, pol_cfg.boost_thresh_c1))) begin
                cpu_st = CPU_BOOST;
            end else if (cpu_st != CPU_RISE && (c0 >= p0 || c1 >= p1)) begin
                cpu_st = CPU_RISE;
                r0 = gear_word(GEAR_0, GEAR_3, 1'b0);
                n = 1;
            end else if (cpu_st != CPU_RESTORE && c0 <= pol_cfg.restore_thresh_c0 &&
                         c1 <= pol_cfg.restore_thresh_c1) begin
                cpu_st = CPU_RESTORE;
                r0 = gear_word(GEAR_1, GEAR_1, 1'b0);
                n = 1;
            end else if (cpu_st != CPU_FALL && c0 < p0 && c1 < p1) begin
                cpu_st = CPU_FALL;
            end
        end

        if (g > pol_cfg.gpu_high_thresh) begin
            lo0 = pol_cfg.band_c0[23:0];
            hi0 = pol_cfg.band_c0[47:24];
            lo1 = pol_cfg.band_c1[23:0];
            hi1 = pol_cfg.band_c1[47:24];
            if (gpu_st != GPU_BELOW && (c0 < lo0 || c1 < lo1)) begin
                gpu_st = GPU_BELOW;
                gpu_w = gear_word(GEAR_3, GEAR_0, 1'b1);
                gpu_hit = 1'b1;
            end else if (gpu_st != GPU_IN && ((c0 >= lo0 && c0 < hi0) ||
                                              (c1 >= lo1 && c1 < hi1))) begin
                gpu_st = GPU_IN;
                gpu_w = gear_word(GEAR_1, GEAR_1, 1'b1);
                gpu_hit = 1'b1;
            end else if (gpu_st != GPU_ABOVE && (c0 >= hi0 || c1 >= hi1)) begin
                gpu_st = GPU_ABOVE;
                gpu_w = gear_word(GEAR_0, GEAR_1, 1'b1);
                gpu_hit = 1'b1;
            end
        end

        if (gpu_hit) begin
            if (n == 0) begin
                r0 = gpu_w;
            end else begin
                r1 = gpu_w;
            end
            n++;
        end
        if (n == 1) begin
            r0.last = 1'b1;
        end else if (n == 2) begin
            r1.last = 1'b1;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (i_cfg_we) begin
                cfg_apply(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                ticks_taken++;
                pred_n = gear_policy_step(i_in_word, pred_a, pred_b);
                if (pred_n == 2) begin
                    dual_ticks++;
                end
                if (pin_valid) begin
                    if (pin_has_gear) begin
                        gear_expect_q.push_back(pin_gear);
                    end
                    pin_valid = 1'b0;
                end else begin
                    if (pred_n > 0) begin
                        gear_expect_q.push_back(pred_a);
                    end
                    if (pred_n > 1) begin
                        gear_expect_q.push_back(pred_b);
                    end
                end
            end
            if (o_out_valid && !i_out_stall) begin
                gears_checked++;
                if (gear_expect_q.size() == 0) begin
                    report_mismatch("word with nothing pending", int'(o_out_word), 0);
                end else begin
                    want_w = gear_expect_q.pop_front();
                    if (o_out_word.cpu_gear !== want_w.cpu_gear) begin
                        report_mismatch("cpu_gear", int'(o_out_word.cpu_gear),
                                        int'(want_w.cpu_gear));
                    end
                    if (o_out_word.gpu_gear !== want_w.gpu_gear) begin
                        report_mismatch("gpu_gear", int'(o_out_word.gpu_gear),
                                        int'(want_w.gpu_gear));
                    end
                    if (o_out_word.from_gpu_policy !== want_w.from_gpu_policy) begin
                        report_mismatch("from_gpu_policy", int'(o_out_word.from_gpu_policy),
                                        int'(want_w.from_gpu_policy));
                    end
                    if (o_out_word.last !== want_w.last) begin
                        report_mismatch("last", int'(o_out_word.last), int'(want_w.last));
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : rx_side
        forever begin
            @(negedge i_clk);
            if (rx_hold_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic void row_item(input logic [23:0] c0, input logic [23:0] c1,
                                     input logic [11:0] g);
        t_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.word = {c0, c1, g};
        dir_rows.push_back(r);
    endfunction

    function automatic void row_quiet(input logic [23:0] c0, input logic [23:0] c1,
                                      input logic [11:0] g);
        t_row r;
        r = '0;
        r.kind = ROW_PINNED;
        r.word = {c0, c1, g};
        dir_rows.push_back(r);
    endfunction

    function automatic void row_gear(input logic [23:0] c0, input logic [23:0] c1,
                                     input logic [11:0] g, input logic [1:0] cg,
                                     input logic [1:0] gg, input logic src);
        t_row r;
        r = '0;
        r.kind = ROW_PINNED;
        r.word = {c0, c1, g};
        r.has_gear = 1'b1;
        r.gear = gear_word(cg, gg, src);
        r.gear.last = 1'b1;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = d;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [23:0] pick_freq(input bit cl);
        logic [23:0] prev, lo, hi, rest, bst, f;
        prev = cl ? hist_c1 : hist_c0;
        lo = cl ? pol_cfg.band_c1[23:0] : pol_cfg.band_c0[23:0];
        hi = cl ? pol_cfg.band_c1[47:24] : pol_cfg.band_c0[47:24];
        rest = cl ? pol_cfg.restore_thresh_c1 : pol_cfg.restore_thresh_c0;
        bst = cl ? pol_cfg.boost_thresh_c1 : pol_cfg.boost_thresh_c0;
        case ($urandom_range(0, 11))
            0: f = '0;
            1: f = '1;
            2, 3: f = 24'($urandom);
            4: f = 24'(lo + $urandom_range(0, 4) - 2);
            5: f = 24'(hi + $urandom_range(0, 4) - 2);
            6: f = 24'(rest + $urandom_range(0, 4) - 2);
            7: f = 24'(prev + bst + $urandom_range(0, 2));
            8: f = 24'(prev - $urandom_range(1, 300000));
            9: f = 24'(prev + $urandom_range(0, 300000));
            default: f = prev;
        endcase
        return f;
    endfunction

    function automatic logic [11:0] pick_gpu();
        logic [11:0] lo, hi, g;
        lo = pol_cfg.gpu_low_thresh;
        hi = pol_cfg.gpu_high_thresh;
        case ($urandom_range(0, 9))
            0: g = '0;
            1: g = '1;
            2: g = 12'($urandom);
            3: g = lo - 12'd1;
            4: g = lo;
            5: g = hi;
            6: g = hi + 12'd1;
            7: g = 12'($urandom_range(0, lo));
            default: g = 12'($urandom_range(hi, 4095));
        endcase
        return g;
    endfunction

    task automatic send_word(input t_in_word w);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (gear_expect_q.size() != 0);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic cfg_write24(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] v);
        logic [23:0] junk;
        junk = 24'($urandom);
        cfg_write(idx, {junk, v});
    endtask

    initial begin : stim
        t_row        r;
        t_in_word    w;
        logic [23:0] lo, hi;
        logic [11:0] gl, gh;
        int          p, k;

        row_gear(24'd0, 24'd0, 12'd0, GEAR_0, GEAR_3, 1'b0);
        row_quiet(24'd1500000, 24'd0, 12'd0);
        row_gear(24'd0, 24'd0, 12'd0, GEAR_1, GEAR_1, 1'b0);
        row_quiet(24'd1500001, 24'd0, 12'd0);
        row_gear(24'd0, 24'hFFFFFF, 12'd0, GEAR_0, GEAR_3, 1'b0);
        row_gear(24'd0, 24'd1200000, 12'd0, GEAR_1, GEAR_1, 1'b0);
        row_gear(24'd1200000, 24'd1300000, 12'd0, GEAR_0, GEAR_3, 1'b0);
        row_quiet(24'd1100000, 24'd1100000, 12'd0);
        row_quiet(24'd1050000, 24'd1050000, 12'd0);
        row_quiet(24'hFFFFFF, 24'hFFFFFF, 12'd443);
        row_gear(24'd0, 24'd0, 12'd442, GEAR_1, GEAR_1, 1'b0);
        row_quiet(24'd0, 24'd0, 12'd607);
        row_gear(24'd0, 24'd0, 12'd608, GEAR_3, GEAR_0, 1'b1);
        row_gear(24'd115200, 24'd1689600, 12'hFFF, GEAR_1, GEAR_1, 1'b1);
        row_gear(24'd1996800, 24'd3072000, 12'hFFF, GEAR_0, GEAR_1, 1'b1);
        row_quiet(24'd1996800, 24'd3072000, 12'hFFF);
        row_gear(24'hFFFFFF, 24'd0, 12'hFFF, GEAR_3, GEAR_0, 1'b1);
        row_cfg(CFG_GPU_LOW, 48'hFFF);
        row_cfg(CFG_GPU_HIGH, 48'd0);
        row_cfg(CFG_BAND_C0, {24'd500000, 24'd500000});
        row_cfg(CFG_BAND_C1, {24'd0, 24'hFFFFFF});
        row_cfg(CFG_IDX_SPARE_LO, '1);
        row_cfg(CFG_IDX_SPARE_HI, '1);
        row_item(24'd500000, 24'd0, 12'd100);
        row_item(24'd0, 24'hFFFFFF, 12'd4094);
        row_item(24'd500000, 24'hFFFFFF, 12'd1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG) begin
                wait_idle();
                cfg_write(r.idx, r.data);
            end else begin
                if (r.kind == ROW_PINNED) begin
                    pin_has_gear = r.has_gear;
                    pin_gear = r.gear;
                    pin_valid = 1'b1;
                end
                send_word(r.word);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            settings_run++;
            tx_idle_on = (p != 3 && p != PHASES - 1);
            rx_idle_on = (p != 5 && p != PHASES - 1);

            if (p == 2) begin
                lo = '0;
            end else if (p == 5) begin
                lo = '1;
            end else begin
                lo = 24'($urandom_range(0, 3000000));
            end
            cfg_write24(CFG_BOOST_C0, lo);
            cfg_write24(CFG_BOOST_C1, (p == 2 || p == 5) ? lo : 24'($urandom_range(0, 3000000)));

            if (p == 3) begin
                lo = '0;
            end else if (p == 6) begin
                lo = '1;
            end else begin
                lo = 24'($urandom_range(0, 3000000));
            end
            cfg_write24(CFG_RESTORE_C0, lo);
            cfg_write24(CFG_RESTORE_C1, (p == 3 || p == 6) ? lo : 24'($urandom_range(0, 3000000)));

            for (k = 0; k < 2; k++) begin
                if (p == 4) begin
                    lo = '1;
                    hi = '1;
                end else if (p == PHASES - 1) begin
                    lo = '0;
                    hi = '0;
                end else begin
                    lo = 24'($urandom_range(0, 3000000));
                    if ($urandom_range(0, 4) == 0) begin
                        hi = 24'($urandom_range(0, lo));
                    end else begin
                        hi = 24'(lo + $urandom_range(1, 3000000));
                    end
                end
                cfg_write((k == 0) ? CFG_BAND_C0 : CFG_BAND_C1, {hi, lo});
            end

            case (p % 4)
                0: begin
                    gl = DEF_GPU_LOW;
                    gh = DEF_GPU_HIGH;
                end
                1: begin
                    gl = '1;
                    gh = '0;
                end
                2: begin
                    gl = 12'($urandom);
                    gh = 12'($urandom);
                end
                default: begin
                    gl = 12'($urandom_range(600, 4095));
                    gh = 12'($urandom_range(0, gl));
                end
            endcase
            cfg_write(CFG_GPU_LOW, {36'($urandom), gl});
            cfg_write(CFG_GPU_HIGH, {36'($urandom), gh});

            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if (p == 1 && k == 20) begin
                    rx_hold_len = HOLD_OFF_CYCLES;
                end
                if (p == 3 && k == 70) begin
                    drain_results();
                end
                w.cpu_freq_c0 = pick_freq(1'b0);
                w.cpu_freq_c1 = pick_freq(1'b1);
                w.gpu_freq_mhz = pick_gpu();
                send_word(w);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(negedge i_clk);
        if (gear_expect_q.size() != 0) begin
            report_mismatch("words never delivered", gear_expect_q.size(), 0);
        end

        $display("covered %0d ticks under %0d threshold settings, %0d gear words checked",
                 ticks_taken, settings_run, gears_checked);
        $display("ticks where both policies reconfigured: %0d, mismatches: %0d",
                 dual_ticks, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
